>>> rtl/core/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Widths, pipeline layout and fixed-point constants of the power report block.
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam int ANT_W   = 3;
  localparam int CAR_W   = 2;
  localparam int RAW_W   = 32;
  localparam int PWR_W   = 11;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // log2 fraction bits, range 12..32
  localparam int LOG_FRAC_BITS = 20;
  localparam int P_W           = 5;
  localparam int LOG_W         = P_W + LOG_FRAC_BITS;
  localparam int Q24_W         = 29;
  localparam int SHR           = (LOG_FRAC_BITS >= 24) ? LOG_FRAC_BITS - 24 : 0;
  localparam int SHL           = (LOG_FRAC_BITS < 24) ? 24 - LOG_FRAC_BITS : 0;
  localparam int EXT_W         = LOG_W + SHL;

  // pipeline positions
  localparam int ST_IN  = 0;
  localparam int ST_NRM = 1;
  localparam int ST_SQ0 = 2;
  localparam int ST_MA  = LOG_FRAC_BITS + 2;
  localparam int ST_MB  = LOG_FRAC_BITS + 3;
  localparam int ST_RD  = LOG_FRAC_BITS + 4;
  localparam int ST_OUT = LOG_FRAC_BITS + 5;
  localparam int NST    = LOG_FRAC_BITS + 6;

  // 1000*log10(2) in Q.24, split in two partial products
  localparam logic [32:0] COEF_Q24 = 33'd5050445260;
  localparam logic [16:0] COEF_HI  = COEF_Q24[32:16];
  localparam logic [15:0] COEF_LO  = COEF_Q24[15:0];

  localparam int H_W = 31;
  localparam logic signed [H_W-1:0] OFS_SUB6_NARROW = -31'sd224382166;
  localparam logic signed [H_W-1:0] OFS_SUB6_WIDE   = -31'sd215207126;
  localparam logic signed [H_W-1:0] OFS_MMW         = -31'sd396971782;
  localparam int ZERO_HUNDREDTHS = -3422;
  localparam int Q16_ONE         = 65536;
  localparam logic signed [H_W-1:0] ZERO_H = H_W'(ZERO_HUNDREDTHS * Q16_ONE);

  localparam logic [30:0] ROUND_HALF = 31'(5 * Q16_ONE);
  localparam logic [15:0] RECIP10    = 16'd52429;

  localparam logic signed [PWR_W-1:0] PWR_MAX = 11'sd1023;
  localparam logic signed [PWR_W-1:0] PWR_MIN = -11'sd1024;

  typedef enum logic [0:0] {
    REG_BAND_MODE = 1'b0,
    REG_WIDE_BAND = 1'b1
  } reg_idx_e;

endpackage

>>> rtl/core/tpd_if.sv
// ----------------------------------------------------------------------------
// tpd_if
// Valid/ready channels for raw readings and power reports.
// ----------------------------------------------------------------------------
interface tpd_in_if;
  import tpd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ANT_W-1:0] antenna;
  logic [CAR_W-1:0] carrier;
  logic [RAW_W-1:0] raw_power;

  modport source (output valid, antenna, carrier, raw_power, input ready);
  modport sink   (input valid, antenna, carrier, raw_power, output ready);
endinterface

interface tpd_out_if;
  import tpd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ANT_W-1:0]        out_antenna;
  logic [CAR_W-1:0]        out_carrier;
  logic signed [PWR_W-1:0] power_tenth_dbm;

  modport source (output valid, out_antenna, out_carrier, power_tenth_dbm, input ready);
  modport sink   (input valid, out_antenna, out_carrier, power_tenth_dbm, output ready);
endinterface

>>> rtl/core/tssi_power_to_tenth_dbm.sv
// ----------------------------------------------------------------------------
// tssi_power_to_tenth_dbm
// Raw carrier power reading to power report in 0.1 dBm steps.
// ----------------------------------------------------------------------------
// One reading is taken per cycle while the first stage can move. The latency
// is set by the log2 fraction chain: one 32x32 squaring stage per fraction
// bit, followed by the split Q.24 coefficient multiply, the offset add, the
// rounding and the saturation stages. Each stage holds while the next is
// full, so bubbles close up and readings keep being taken while a report
// waits, until every stage is full. band_mode and wide_band are read live
// and must only be written while no reading is in flight.
module tssi_power_to_tenth_dbm (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tpd_in_if.sink                       in_i,
  tpd_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpd_pkg::PADDR_W-1:0]  paddr,
  input  logic [tpd_pkg::PDATA_W-1:0]  pwdata,
  output logic [tpd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import tpd_pkg::*;

  // configuration
  logic band_mode_q, band_mode_d;
  logic wide_band_q, wide_band_d;
  reg_idx_e reg_idx;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    band_mode_d = band_mode_q;
    wide_band_d = wide_band_q;
    if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_BAND_MODE: band_mode_d = pwdata[0];
        REG_WIDE_BAND: wide_band_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BAND_MODE: prdata = PDATA_W'(band_mode_q);
      REG_WIDE_BAND: prdata = PDATA_W'(wide_band_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_mode_q <= 1'b0;
      wide_band_q <= 1'b0;
    end else begin
      band_mode_q <= band_mode_d;
      wide_band_q <= wide_band_d;
    end
  end

  // stage flow control
  logic [NST-1:0] v_q;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[NST-1] = !v_q[NST-1] || out_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_i.ready = rdy[0];

  // tags follow every stage
  logic [ANT_W-1:0] ant_q [NST];
  logic [CAR_W-1:0] car_q [NST];

  always_ff @(posedge clk_i) begin
    if (rdy[ST_IN]) begin
      ant_q[ST_IN] <= in_i.antenna;
      car_q[ST_IN] <= in_i.carrier;
    end
    for (int k = 1; k < NST; k++) begin
      if (rdy[k]) begin
        ant_q[k] <= ant_q[k-1];
        car_q[k] <= car_q[k-1];
      end
    end
  end

  // input register
  logic [RAW_W-1:0] raw_q;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_IN]) raw_q <= in_i.raw_power;
  end

  // leading-one detect and normalise to Q1.31
  logic [P_W-1:0]   lead;
  logic [RAW_W-1:0] m_nrm;

  always_comb begin
    lead = '0;
    for (int i = 0; i < RAW_W; i++) begin
      if (raw_q[i]) lead = P_W'(i);
    end
    m_nrm = raw_q << (~lead);
  end

  logic [RAW_W-1:0]         m_q    [LOG_FRAC_BITS];
  logic [P_W-1:0]           p_q    [LOG_FRAC_BITS+1];
  logic [LOG_FRAC_BITS-1:0] frac_q [1:LOG_FRAC_BITS];
  logic                     zero_q [ST_NRM:ST_MA];

  always_ff @(posedge clk_i) begin
    if (rdy[ST_NRM]) begin
      m_q[0]         <= m_nrm;
      p_q[0]         <= lead;
      zero_q[ST_NRM] <= (raw_q == '0);
    end
    for (int k = ST_NRM + 1; k <= ST_MA; k++) begin
      if (rdy[k]) zero_q[k] <= zero_q[k-1];
    end
  end

  // one fraction bit per squaring stage
  for (genvar j = 0; j < LOG_FRAC_BITS; j++) begin : g_sq
    logic [2*RAW_W-1:0]       sq;
    logic [RAW_W:0]           t;
    logic                     fbit;
    logic [LOG_FRAC_BITS-1:0] frac_in;

    assign sq    = 64'(m_q[j]) * 64'(m_q[j]);
    assign t     = sq[2*RAW_W-1:RAW_W-1];
    assign fbit  = t[RAW_W];

    if (j == 0) begin : g_first
      assign frac_in = '0;
    end else begin : g_rest
      assign frac_in = frac_q[j];
    end

    always_ff @(posedge clk_i) begin
      if (rdy[ST_SQ0+j]) begin
        frac_q[j+1] <= LOG_FRAC_BITS'({frac_in, fbit});
        p_q[j+1]    <= p_q[j];
      end
    end

    if (j < LOG_FRAC_BITS - 1) begin : g_m
      logic [RAW_W-1:0] m_nxt;

      assign m_nxt = fbit ? t[RAW_W:1] : t[RAW_W-1:0];

      always_ff @(posedge clk_i) begin
        if (rdy[ST_SQ0+j]) m_q[j+1] <= m_nxt;
      end
    end
  end

  // Q.24 log2 times 1000*log10(2), two partial products
  logic [LOG_W-1:0] log2_v;
  logic [EXT_W-1:0] log2_ext;
  logic [Q24_W-1:0] q24;
  logic [45:0]      pph_q;
  logic [44:0]      ppl_q;

  assign log2_v   = {p_q[LOG_FRAC_BITS], frac_q[LOG_FRAC_BITS]};
  assign log2_ext = EXT_W'(log2_v) << SHL;
  assign q24      = Q24_W'(log2_ext >> SHR);

  always_ff @(posedge clk_i) begin
    if (rdy[ST_MA]) begin
      pph_q <= 46'(q24) * 46'(COEF_HI);
      ppl_q <= 45'(q24) * 45'(COEF_LO);
    end
  end

  // hundredths in Q.16 plus band offset
  logic [61:0]             prod;
  logic signed [H_W-1:0]   ofs;
  logic signed [H_W-1:0]   h_d;
  logic signed [H_W-1:0]   h_q;

  always_comb begin
    prod = {pph_q, 16'b0} + 62'(ppl_q);
    if (band_mode_q)      ofs = OFS_MMW;
    else if (wide_band_q) ofs = OFS_SUB6_WIDE;
    else                  ofs = OFS_SUB6_NARROW;
    if (zero_q[ST_MA]) h_d = ZERO_H;
    else               h_d = $signed({1'b0, prod[61:32]}) + ofs;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_MB]) h_q <= h_d;
  end

  // round half away: magnitude / 10 by reciprocal
  logic [29:0] h_abs;
  logic [30:0] h_rnd;
  logic [14:0] y;
  logic        neg_q;
  logic [30:0] p10_q;

  always_comb begin
    h_abs = h_q[H_W-1] ? 30'(-h_q) : 30'(h_q);
    h_rnd = 31'(h_abs) + ROUND_HALF;
    y     = h_rnd[30:16];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_RD]) begin
      neg_q <= h_q[H_W-1];
      p10_q <= 31'(y) * 31'(RECIP10);
    end
  end

  // sign and saturate
  logic [11:0]             mag;
  logic signed [PWR_W-1:0] pwr_d;
  logic signed [PWR_W-1:0] pwr_q;

  always_comb begin
    mag = p10_q[30:19];
    if (!neg_q) begin
      pwr_d = (mag > 12'd1023) ? PWR_MAX : PWR_W'(mag);
    end else begin
      pwr_d = (mag > 12'd1024) ? PWR_MIN : PWR_W'(-$signed({1'b0, mag}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_OUT]) pwr_q <= pwr_d;
  end

  assign out_o.valid           = v_q[ST_OUT];
  assign out_o.out_antenna     = ant_q[ST_OUT];
  assign out_o.out_carrier     = car_q[ST_OUT];
  assign out_o.power_tenth_dbm = pwr_q;

endmodule

>>> tb/tpd_power_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpd_power_check
// Scoreboard for the power report block: follows the register writes on the
// APB port, works out the report due for every reading transfer and compares
// each report transfer, field by field, against the oldest one outstanding.
// Register read-back is checked against the same shadow copy.
// ----------------------------------------------------------------------------
module tpd_power_check
  import tpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  tpd_in_if                  in_i,
  tpd_out_if                 out_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  input  logic [PDATA_W-1:0] prdata_i,
  input  logic               pready_i,
  output int                 fail_cnt_o,
  output int                 pending_o,
  output int                 checked_o
);

  localparam longint HALF_TENTH = 5 * longint'(Q16_ONE);
  localparam longint ONE_TENTH  = 10 * longint'(Q16_ONE);

  typedef struct {
    logic [RAW_W-1:0]        raw;
    logic [ANT_W-1:0]        antenna;
    logic [CAR_W-1:0]        carrier;
    logic signed [PWR_W-1:0] tenth_dbm;
  } power_report_t;

  power_report_t     report_q[$];
  power_report_t     want;
  logic              band_sh;
  logic              wide_sh;
  logic [PDATA_W-1:0] reg_val;
  reg_idx_e          reg_sel;
  int                fails;
  int                checked;

  assign fail_cnt_o = fails;
  assign checked_o  = checked;
  assign pending_o  = report_q.size();

  // 10*log10(raw/K) + offset in tenths of a dB, built in Q.16 hundredths
  function automatic logic signed [PWR_W-1:0] tenth_dbm_of(
      input logic [RAW_W-1:0] raw, input logic band, input logic wide);
    int          lead;
    logic [63:0] mant;
    logic [63:0] frac;
    logic [63:0] lg;
    logic [63:0] prod;
    longint      hund;
    longint      ofs;
    longint      rnd;
    if (raw == '0) begin
      hund = longint'(ZERO_HUNDREDTHS) * longint'(Q16_ONE);
    end else begin
      lead = RAW_W - 1;
      while (lead > 0 && !raw[lead]) lead--;
      mant = 64'(raw) << (31 - lead);
      frac = '0;
      for (int i = 0; i < LOG_FRAC_BITS; i++) begin
        mant = (mant * mant) >> 31;
        frac = frac << 1;
        if (mant >= 64'h1_0000_0000) begin
          mant = mant >> 1;
          frac = frac | 64'd1;
        end
      end
      lg   = (64'(lead) << LOG_FRAC_BITS) | frac;
      lg   = (lg >> SHR) << SHL;
      prod = lg * 64'(COEF_Q24);
      if (band)
        ofs = longint'(OFS_MMW);
      else if (wide)
        ofs = longint'(OFS_SUB6_WIDE);
      else
        ofs = longint'(OFS_SUB6_NARROW);
      hund = longint'(prod >> 32) + ofs;
    end
    if (hund >= 0)
      rnd = (hund + HALF_TENTH) / ONE_TENTH;
    else
      rnd = -((-hund + HALF_TENTH) / ONE_TENTH);
    if (rnd > longint'(PWR_MAX)) rnd = longint'(PWR_MAX);
    if (rnd < longint'(PWR_MIN)) rnd = longint'(PWR_MIN);
    return PWR_W'(rnd);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_sh = 1'b0;
      wide_sh = 1'b0;
      report_q.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        reg_sel = reg_idx_e'(paddr_i[PADDR_W-1:2]);
        if (pwrite_i) begin
          case (reg_sel)
            REG_BAND_MODE: band_sh = pwdata_i[0];
            REG_WIDE_BAND: wide_sh = pwdata_i[0];
            default: ;
          endcase
        end else begin
          reg_val = (reg_sel == REG_BAND_MODE) ? PDATA_W'(band_sh) : PDATA_W'(wide_sh);
          if (prdata_i !== reg_val) begin
            fails++;
            $display("%0t: read-back of %s: expected %0h, got %0h",
                     $time, reg_sel.name(), reg_val, prdata_i);
          end
        end
      end

      if (out_i.valid && out_i.ready) begin
        if (report_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected report: antenna %0d carrier %0d power %0d",
                   $time, out_i.out_antenna, out_i.out_carrier, out_i.power_tenth_dbm);
        end else begin
          want = report_q.pop_front();
          checked++;
          if (out_i.out_antenna !== want.antenna) begin
            fails++;
            $display("%0t: raw %0h antenna: expected %0d, got %0d",
                     $time, want.raw, want.antenna, out_i.out_antenna);
          end
          if (out_i.out_carrier !== want.carrier) begin
            fails++;
            $display("%0t: raw %0h carrier: expected %0d, got %0d",
                     $time, want.raw, want.carrier, out_i.out_carrier);
          end
          if (out_i.power_tenth_dbm !== want.tenth_dbm) begin
            fails++;
            $display("%0t: raw %0h power: expected %0d, got %0d",
                     $time, want.raw, want.tenth_dbm, out_i.power_tenth_dbm);
          end
        end
      end

      if (in_i.valid && in_i.ready) begin
        want.raw       = in_i.raw_power;
        want.antenna   = in_i.antenna;
        want.carrier   = in_i.carrier;
        want.tenth_dbm = tenth_dbm_of(in_i.raw_power, band_sh, wide_sh);
        report_q.push_back(want);
      end
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the power report block: directed readings at the
// edges of the range under each radio setting, then random phases that cycle
// through band and bandwidth settings and through sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
  import tpd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 50;

  typedef enum int {
    FLOW_FREE,
    FLOW_TX_IDLE,
    FLOW_RX_STALL,
    FLOW_BOTH
  } flow_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int          fail_cnt;
  int          pending;
  int          checked;
  int          sent;
  int          cycles = 0;

  logic [RAW_W-1:0] edge_readings[8] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0003, 32'h8000_0000,
    32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1878452,   32'd37820814
  };

  tpd_in_if  reading_ch();
  tpd_out_if report_ch();

  tssi_power_to_tenth_dbm u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (reading_ch),
    .out_o   (report_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tpd_power_check u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (reading_ch),
    .out_i      (report_ch),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_i   (prdata),
    .pready_i   (pready),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    report_ch.ready <= !(rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles, pending);
      $display("[tssi_power_to_tenth_dbm] ERROR");
      $finish;
    end
  end

  task automatic set_flow(input flow_e mode);
    case (mode)
      FLOW_FREE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      FLOW_TX_IDLE:  begin tx_idle_pct = 62; rx_stall_pct = 0;  end
      FLOW_RX_STALL: begin tx_idle_pct = 0;  rx_stall_pct = 62; end
      default:       begin tx_idle_pct = 30; rx_stall_pct = 30; end
    endcase
  endtask

  // psel stays high between back-to-back transfers; apb_release drops it
  task automatic apb_access(input reg_idx_e idx, input logic wr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_radio_mode(input logic band, input logic wide);
    reading_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    apb_access(REG_BAND_MODE, 1'b1, PDATA_W'(band));
    apb_access(REG_WIDE_BAND, 1'b1, PDATA_W'(wide));
    apb_access(REG_BAND_MODE, 1'b0, '0);
    apb_access(REG_WIDE_BAND, 1'b0, '0);
    apb_release();
  endtask

  task automatic send_reading(input logic [ANT_W-1:0] ant, input logic [CAR_W-1:0] car,
                              input logic [RAW_W-1:0] raw);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      reading_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    reading_ch.valid     <= 1'b1;
    reading_ch.antenna   <= ant;
    reading_ch.carrier   <= car;
    reading_ch.raw_power <= raw;
    do @(posedge clk_i); while (!reading_ch.ready);
    @(negedge clk_i);
    sent++;
  endtask

  // spread of leading-one positions, with zero and single-bit readings mixed in
  function automatic logic [RAW_W-1:0] random_reading();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:          return '0;
      1:          return RAW_W'(1) << $urandom_range(0, RAW_W - 1);
      2, 3, 4, 5: return RAW_W'($urandom) >> $urandom_range(0, RAW_W - 1);
      6:          return RAW_W'($urandom_range(1, 255));
      default:    return RAW_W'($urandom);
    endcase
  endfunction

  initial begin
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    reading_ch.valid     = 1'b0;
    reading_ch.antenna   = '0;
    reading_ch.carrier   = '0;
    reading_ch.raw_power = '0;
    tx_idle_pct          = 0;
    rx_stall_pct         = 0;
    sent                 = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // edge readings under narrow sub6, wide sub6 and mmW with the wide flag set
    set_flow(FLOW_FREE);
    for (int m = 0; m < 3; m++) begin
      set_radio_mode(m == 2, m != 0);
      foreach (edge_readings[i]) begin
        send_reading((i % 2) ? ANT_W'(7) : ANT_W'(i), (i % 2) ? CAR_W'(0) : CAR_W'(3),
                     edge_readings[i]);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      set_radio_mode(ph[1], ph[0]);
      set_flow(flow_e'((ph + ph / 4) % 4));
      repeat (PHASE_ITEMS) begin
        send_reading(ANT_W'($urandom), CAR_W'($urandom), random_reading());
      end
    end

    reading_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (NST + 4) @(negedge clk_i);

    $display("Sent %0d readings over all four band/bandwidth settings and four flow mixes;",
             sent);
    $display("%0d power reports compared, %0d failures.", checked, fail_cnt);
    if (fail_cnt == 0) begin
      $display("[tssi_power_to_tenth_dbm] OK");
    end else begin
      $display("[tssi_power_to_tenth_dbm] ERROR");
    end
    $finish;
  end

endmodule
